// ===== rtl/icmp_echo_responder_macros.svh =====
// ----------------------------------------------------------------------------
// ICMP echo responder assertion macros
// Concurrent assertion wrappers; empty bodies when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ICMP_ECHO_RESPONDER_MACROS_SVH
`define ICMP_ECHO_RESPONDER_MACROS_SVH

`ifndef SYNTH
`define ER_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ER_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ER_ASSERT(lbl, clk, rstn, prop, msg)
`define ER_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/icmp_er_pkg.sv =====
// ----------------------------------------------------------------------------
// ICMP echo responder package
// Status and command codes, defaults and controller command struct.
// ----------------------------------------------------------------------------
`default_nettype none

package icmp_er_pkg;

	localparam int MAX_MESSAGE_BYTES_DEF = 2048;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_PULL = 1'b1;

	localparam logic [2:0] ST_TAKEN = 3'd0;
	localparam logic [2:0] ST_READY = 3'd1;
	localparam logic [2:0] ST_DROP  = 3'd2;
	localparam logic [2:0] ST_BYTE  = 3'd3;
	localparam logic [2:0] ST_NONE  = 3'd4;

	localparam logic [7:0] ECHO_REQUEST = 8'd8;

	typedef struct packed {
		logic exec;
		logic load;
	} ctrl_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/icmp_echo_responder.sv =====
// ----------------------------------------------------------------------------
// ICMP echo responder
// Usage:
//   Input channel (in_valid/in_ready) carries one beat per command: a push
//   with command 0 stores one received ICMP byte (end_of_packet on the last),
//   a pull with command 1 requests the next echo reply byte.
//   Output channel (out_valid/out_ready) returns exactly one result beat per
//   input beat: status, reply_byte, reply_last, reply_address.
//   A taken beat's result and its registered store read land in the result
//   registers; the finish step then loads them into the output register.
//   The controller does not take the next item until that load is done;
//   in_ready is low throughout the finish step.
//   An accepted item whose predecessor's result still waits holds in the
//   finish step until the receiver takes that beat; in_ready stays low.
//   Reset clears all message state, the checksum and the output valid flag;
//   the message store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module icmp_echo_responder import icmp_er_pkg::*; #(
	parameter int MAX_MESSAGE_BYTES = MAX_MESSAGE_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        command,
	input  wire logic [7:0]  data_byte,
	input  wire logic        end_of_packet,
	input  wire logic [31:0] peer_address,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       status,
	output logic [7:0]       reply_byte,
	output logic             reply_last,
	output logic [31:0]      reply_address
);

	ctrl_cmd_t cmd;

	icmp_er_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	icmp_er_datapath #(
		.MAX_BYTES (MAX_MESSAGE_BYTES)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.command       (command),
		.data_byte     (data_byte),
		.end_of_packet (end_of_packet),
		.peer_address  (peer_address),
		.status        (status),
		.reply_byte    (reply_byte),
		.reply_last    (reply_last),
		.reply_address (reply_address)
	);

endmodule

`default_nettype wire

// ===== rtl/icmp_er_datapath.sv =====
// ----------------------------------------------------------------------------
// ICMP echo responder datapath
// Message store, running checksum, reply read-out and output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "icmp_echo_responder_macros.svh"

module icmp_er_datapath import icmp_er_pkg::*; #(
	parameter int MAX_BYTES = MAX_MESSAGE_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire ctrl_cmd_t   cmd,
	input  wire logic        command,
	input  wire logic [7:0]  data_byte,
	input  wire logic        end_of_packet,
	input  wire logic [31:0] peer_address,
	output logic [2:0]       status,
	output logic [7:0]       reply_byte,
	output logic             reply_last,
	output logic [31:0]      reply_address
);

	localparam int LEN_W = $clog2(MAX_BYTES + 1);
	localparam int IDX_W = $clog2(MAX_BYTES);
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_BYTES);
	localparam logic [LEN_W-1:0] MIN_LEN = LEN_W'(8);

	function automatic logic [15:0] fold_sum(input logic [31:0] s);
		logic [16:0] a;
		logic [16:0] b;
		a = {1'b0, s[15:0]} + {1'b0, s[31:16]};
		b = {1'b0, a[15:0]} + {16'b0, a[16]};
		return ~(b[15:0]);
	endfunction

	logic [7:0]       mem [MAX_BYTES];
	logic [7:0]       rd_data_q;

	logic [LEN_W-1:0] len_q, len_d, len_e;
	logic [LEN_W-1:0] pos_q, pos_d;
	logic [31:0]      sum_q, sum_d, sum_e;
	logic [31:0]      sender_q, sender_d;
	logic             pend_q, pend_d;
	logic             ovf_q, ovf_d, ovf_e;
	logic             echo_q, echo_d;
	logic [15:0]      cksum_q;

	logic             we, re;
	logic [IDX_W-1:0] waddr, raddr;

	logic [2:0]       res_status_d, res_status_q;
	logic [7:0]       res_byte_d, res_byte_q;
	logic             res_mem_d, res_mem_q;
	logic             res_last_d, res_last_q;
	logic [31:0]      res_addr_d, res_addr_q;
	logic             res_fold_d, res_fold_q;

	always_comb begin
		len_e        = pend_q ? '0 : len_q;
		ovf_e        = pend_q ? 1'b0 : ovf_q;
		sum_e        = pend_q ? '0 : sum_q;
		len_d        = len_q;
		pos_d        = pos_q;
		sum_d        = sum_q;
		sender_d     = sender_q;
		pend_d       = pend_q;
		ovf_d        = ovf_q;
		echo_d       = echo_q;
		we           = 1'b0;
		re           = 1'b0;
		waddr        = len_e[IDX_W-1:0];
		raddr        = pos_q[IDX_W-1:0];
		res_status_d = ST_TAKEN;
		res_byte_d   = '0;
		res_mem_d    = 1'b0;
		res_last_d   = 1'b0;
		res_addr_d   = '0;
		res_fold_d   = 1'b0;
		if (cmd.exec) begin
			if (command == CMD_PUSH) begin
				len_d  = len_e;
				sum_d  = sum_e;
				ovf_d  = ovf_e;
				pend_d = 1'b0;
				if (pend_q) begin
					pos_d = '0;
				end
				if (len_e == '0 && !ovf_e) begin
					sender_d = peer_address;
				end
				if (len_e < MAX_LEN) begin
					we = 1'b1;
					if (len_e == '0) begin
						echo_d = (data_byte == ECHO_REQUEST);
					end
					if (len_e != LEN_W'(0) && len_e != LEN_W'(2) && len_e != LEN_W'(3)) begin
						sum_d = sum_e + (len_e[0] ? {24'b0, data_byte} : {16'b0, data_byte, 8'b0});
					end
					len_d = len_e + LEN_W'(1);
				end else begin
					ovf_d = 1'b1;
				end
				if (end_of_packet) begin
					if (ovf_d || len_d < MIN_LEN || !echo_d) begin
						len_d        = '0;
						sum_d        = '0;
						pos_d        = '0;
						pend_d       = 1'b0;
						ovf_d        = 1'b0;
						res_status_d = ST_DROP;
					end else begin
						pos_d        = '0;
						pend_d       = 1'b1;
						res_status_d = ST_READY;
						res_addr_d   = sender_d;
						res_fold_d   = 1'b1;
					end
				end
			end else begin
				if (!pend_q || pos_q >= len_q) begin
					res_status_d = ST_NONE;
				end else begin
					re           = 1'b1;
					res_status_d = ST_BYTE;
					res_addr_d   = sender_q;
					case (pos_q)
						LEN_W'(0): res_byte_d = '0;
						LEN_W'(2): res_byte_d = cksum_q[15:8];
						LEN_W'(3): res_byte_d = cksum_q[7:0];
						default:   res_mem_d  = 1'b1;
					endcase
					if ((pos_q + LEN_W'(1)) >= len_q) begin
						res_last_d = 1'b1;
						len_d      = '0;
						sum_d      = '0;
						pos_d      = '0;
						pend_d     = 1'b0;
						ovf_d      = 1'b0;
					end else begin
						pos_d = pos_q + LEN_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= data_byte;
		end
		if (re) begin
			rd_data_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			pos_q    <= '0;
			sum_q    <= '0;
			sender_q <= '0;
			pend_q   <= 1'b0;
			ovf_q    <= 1'b0;
			echo_q   <= 1'b0;
			cksum_q  <= '0;
		end else begin
			len_q    <= len_d;
			pos_q    <= pos_d;
			sum_q    <= sum_d;
			sender_q <= sender_d;
			pend_q   <= pend_d;
			ovf_q    <= ovf_d;
			echo_q   <= echo_d;
			if (cmd.load && res_fold_q) begin
				cksum_q <= fold_sum(sum_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_status_q <= res_status_d;
			res_byte_q   <= res_byte_d;
			res_mem_q    <= res_mem_d;
			res_last_q   <= res_last_d;
			res_addr_q   <= res_addr_d;
			res_fold_q   <= res_fold_d;
		end
		if (cmd.load) begin
			status        <= res_status_q;
			reply_byte    <= res_mem_q ? rd_data_q : res_byte_q;
			reply_last    <= res_last_q;
			reply_address <= res_addr_q;
		end
	end

	`ER_ASSERT(a_pend_len, clk, arst_n, pend_q |-> (len_q >= MIN_LEN), "reply pending with short message")
	`ER_ASSERT(a_pos_len, clk, arst_n, pos_q <= len_q, "read position past message length")
	`ER_ASSERT(a_ovf_full, clk, arst_n, ovf_q |-> (len_q == MAX_LEN), "overflow with store not full")
	`ER_ASSERT(a_pend_ovf, clk, arst_n, pend_q |-> !ovf_q, "reply pending after overflow")

endmodule

`default_nettype wire

// ===== rtl/icmp_er_ctrl.sv =====
// ----------------------------------------------------------------------------
// ICMP echo responder controller
// Sequences accept and result delivery; owns the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module icmp_er_ctrl import icmp_er_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	output ctrl_cmd_t cmd
);

	typedef enum logic {
		S_IDLE,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign cmd.exec  = in_valid && in_ready;
	assign cmd.load  = (state_q == S_FINISH) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.exec) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (cmd.load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== tb/sv/echo_reply_tracker_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ICMP echo reply tracker
// Tracks the responder's message and reply state beat by beat, keeps the
// results each command beat must produce, and compares returned beats
// against them in order.
// ----------------------------------------------------------------------------
package echo_reply_tracker_pkg;

	import icmp_er_pkg::*;

	class echo_reply_tracker;

		typedef struct {
			logic [2:0]  status;
			logic [7:0]  rbyte;
			logic        rlast;
			logic [31:0] raddr;
		} reply_beat_t;

		reply_beat_t  awaited_beats[$];
		logic [7:0]   msg_bytes [MAX_MESSAGE_BYTES_DEF];
		int unsigned  msg_len = 0;
		int unsigned  read_pos = 0;
		logic [31:0]  sum_acc = '0;
		logic [31:0]  src_addr = '0;
		logic [15:0]  reply_csum = '0;
		bit           reply_pending = 1'b0;
		bit           overflowed = 1'b0;
		int unsigned  error_count = 0;

		function void clear_message();
			msg_len = 0;
			sum_acc = '0;
			read_pos = 0;
			reply_pending = 1'b0;
			overflowed = 1'b0;
		endfunction

		function void absorb_command(logic cmd, logic [7:0] b, logic eop, logic [31:0] peer);
			reply_beat_t r;
			int unsigned pos;
			logic [31:0] folded;
			r = '{status: ST_TAKEN, rbyte: 8'h00, rlast: 1'b0, raddr: 32'h0};
			if (cmd == CMD_PUSH) begin
				if (reply_pending)
					clear_message();
				if (msg_len == 0 && !overflowed)
					src_addr = peer;
				if (msg_len < MAX_MESSAGE_BYTES_DEF) begin
					pos = msg_len;
					msg_bytes[pos] = b;
					if (pos != 0 && pos != 2 && pos != 3)
						sum_acc += pos[0] ? {24'd0, b} : {16'd0, b, 8'd0};
					msg_len = pos + 1;
				end else begin
					overflowed = 1'b1;
				end
				if (eop) begin
					if (overflowed || msg_len < 8 || msg_bytes[0] != ECHO_REQUEST) begin
						clear_message();
						r.status = ST_DROP;
					end else begin
						folded = {16'd0, sum_acc[15:0]} + {16'd0, sum_acc[31:16]};
						folded = {16'd0, folded[15:0]} + {16'd0, folded[31:16]};
						reply_csum = ~folded[15:0];
						read_pos = 0;
						reply_pending = 1'b1;
						r.status = ST_READY;
						r.raddr = src_addr;
					end
				end
			end else begin
				if (!reply_pending || read_pos >= msg_len) begin
					r.status = ST_NONE;
				end else begin
					pos = read_pos;
					case (pos)
						0: r.rbyte = 8'h00;
						2: r.rbyte = reply_csum[15:8];
						3: r.rbyte = reply_csum[7:0];
						default: r.rbyte = msg_bytes[pos];
					endcase
					r.status = ST_BYTE;
					r.raddr = src_addr;
					if (pos + 1 >= msg_len) begin
						r.rlast = 1'b1;
						clear_message();
					end else begin
						read_pos = pos + 1;
					end
				end
			end
			awaited_beats.push_back(r);
		endfunction

		task report(string msg);
			$display("[%0t] MISMATCH %s", $time, msg);
			error_count++;
		endtask

		task check_reply_beat(logic [2:0] status, logic [7:0] rbyte, logic rlast,
				logic [31:0] raddr);
			reply_beat_t want;
			if (awaited_beats.size() == 0) begin
				report($sformatf("result beat with nothing awaited, status %0d", status));
			end else begin
				want = awaited_beats.pop_front();
				if (status !== want.status)
					report($sformatf("status got %0d expected %0d", status, want.status));
				if (rbyte !== want.rbyte)
					report($sformatf("reply_byte got %0h expected %0h", rbyte, want.rbyte));
				if (rlast !== want.rlast)
					report($sformatf("reply_last got %0d expected %0d", rlast, want.rlast));
				if (raddr !== want.raddr)
					report($sformatf("reply_address got %0h expected %0h", raddr, want.raddr));
			end
		endtask

	endclass

endpackage

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ICMP echo responder testbench
// Pushes received ICMP messages and pulls echo replies through the command
// channel, with bursty input and a stalling result side. Every result beat
// is checked against a tracked copy of the responder state: directed edge
// cases, then mostly well-formed random echo requests mixed with bad types,
// short messages and noise.
// ----------------------------------------------------------------------------
module tb_top;

	import icmp_er_pkg::*;
	import echo_reply_tracker_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int RANDOM_BEATS = 1530;
	localparam int HOLD_CYCLES  = 400;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        command;
	logic [7:0]  data_byte;
	logic        end_of_packet;
	logic [31:0] peer_address;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  status;
	logic [7:0]  reply_byte;
	logic        reply_last;
	logic [31:0] reply_address;

	echo_reply_tracker tracker = new;

	int unsigned beats_sent = 0;
	int unsigned burst_left = 0;
	int unsigned cycle_count;
	bit          hold_req = 1'b0;

	icmp_echo_responder u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.data_byte     (data_byte),
		.end_of_packet (end_of_packet),
		.peer_address  (peer_address),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.reply_byte    (reply_byte),
		.reply_last    (reply_last),
		.reply_address (reply_address)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task send_beat(logic cmd, logic [7:0] b, logic eop, logic [31:0] peer);
		int unsigned gap;
		in_valid      <= 1'b1;
		command       <= cmd;
		data_byte     <= b;
		end_of_packet <= eop;
		peer_address  <= peer;
		do @(posedge clk); while (!in_ready);
		tracker.absorb_command(cmd, b, eop, peer);
		beats_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(0, 12);
		end
	endtask

	task push_message(int unsigned len, logic [7:0] type_byte, logic [31:0] peer);
		int unsigned i;
		for (i = 0; i < len; i++)
			send_beat(CMD_PUSH, (i == 0) ? type_byte : 8'($urandom_range(0, 255)),
				i == len - 1, (i == 0) ? peer : $urandom);
	endtask

	task pull_bytes(int unsigned n);
		repeat (n) send_beat(CMD_PULL, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
			$urandom);
	endtask

	task drain_replies();
		in_valid <= 1'b0;
		while (tracker.awaited_beats.size() != 0) @(posedge clk);
	endtask

	// result side: stall pattern, one long hold-off on request
	initial begin
		int unsigned hold_left;
		int unsigned rx_cycle;
		int unsigned mode;
		hold_left = 0;
		rx_cycle = 0;
		mode = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				tracker.check_reply_beat(status, reply_byte, reply_last, reply_address);
			rx_cycle++;
			if (rx_cycle % 256 == 0)
				mode = $urandom_range(0, 3);
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= (rx_cycle % 5) > 1;
					default: out_ready <= $urandom_range(0, 7) != 0;
				endcase
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int unsigned random_start;
		int unsigned choice;
		int unsigned len;
		int unsigned pick;
		logic [7:0]  type_byte;
		bit          hold_done;
		bit          drain_done;
		hold_done = 1'b0;
		drain_done = 1'b0;
		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		command       <= CMD_PUSH;
		data_byte     <= 8'h00;
		end_of_packet <= 1'b0;
		peer_address  <= 32'h0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pull with no reply, then a reply abandoned by a new message
		send_beat(CMD_PULL, 8'hFF, 1'b1, 32'hFFFF_FFFF);
		send_beat(CMD_PUSH, ECHO_REQUEST, 1'b0, 32'hFFFF_FFFF);
		send_beat(CMD_PUSH, 8'h00, 1'b0, 32'h0);
		send_beat(CMD_PUSH, 8'hA5, 1'b0, 32'h0);
		send_beat(CMD_PUSH, 8'h5A, 1'b0, 32'h0);
		send_beat(CMD_PUSH, 8'hFF, 1'b0, 32'h0);
		send_beat(CMD_PUSH, 8'hFF, 1'b0, 32'h0);
		send_beat(CMD_PUSH, 8'h00, 1'b0, 32'h0);
		send_beat(CMD_PUSH, 8'hFF, 1'b1, 32'h0);
		pull_bytes(3);
		send_beat(CMD_PUSH, ECHO_REQUEST, 1'b0, 32'h0);
		repeat (3) send_beat(CMD_PUSH, 8'h00, 1'b0, 32'hFFFF_FFFF);
		send_beat(CMD_PUSH, 8'h00, 1'b1, 32'hFFFF_FFFF);
		pull_bytes(1);
		send_beat(CMD_PUSH, ECHO_REQUEST, 1'b1, 32'h1234_5678);

		random_start = beats_sent;
		while (beats_sent - random_start < RANDOM_BEATS) begin
			if (!hold_done && beats_sent - random_start > 400) begin
				hold_req = 1'b1;
				hold_done = 1'b1;
			end
			if (!drain_done && beats_sent - random_start > 1000) begin
				drain_replies();
				drain_done = 1'b1;
			end
			choice = $urandom_range(0, 99);
			if (choice < 70) begin
				len = ($urandom_range(0, 15) == 0) ? $urandom_range(41, 300)
					: $urandom_range(8, 40);
				push_message(len, ECHO_REQUEST, $urandom);
				pick = $urandom_range(0, 9);
				if (pick < 7)
					pull_bytes(len);
				else if (pick == 7)
					pull_bytes(len + $urandom_range(1, 3));
				else
					pull_bytes($urandom_range(1, len - 1));
			end else if (choice < 80) begin
				do type_byte = 8'($urandom_range(0, 255)); while (type_byte == ECHO_REQUEST);
				push_message($urandom_range(8, 20), type_byte, $urandom);
				pull_bytes($urandom_range(0, 2));
			end else if (choice < 90) begin
				type_byte = $urandom_range(0, 1) ? ECHO_REQUEST : 8'($urandom_range(0, 255));
				push_message($urandom_range(1, 7), type_byte, $urandom);
				pull_bytes($urandom_range(0, 2));
			end else begin
				repeat ($urandom_range(1, 5))
					send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)), $urandom);
			end
		end

		drain_replies();
		repeat (10) @(posedge clk);
		if (tracker.error_count == 0 && tracker.awaited_beats.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
